// ===== rtl/vital_sign_median_ema_filter_assert.svh =====
// Assertion macros shared by the filter's modules.
// Each expects aclk and aresetn in scope.
`ifndef VITAL_SIGN_MEDIAN_EMA_FILTER_ASSERT_SVH
`define VITAL_SIGN_MEDIAN_EMA_FILTER_ASSERT_SVH

// same-cycle implication
`define VSMEF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("vsmef: same-cycle check failed");

// next-cycle implication
`define VSMEF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("vsmef: next-cycle check failed");

`endif

// ===== rtl/vsmef_pkg.sv =====
package vsmef_pkg;

    localparam int WINDOW_DEF = 5;

    localparam logic [31:0] WARMUP_RST = 32'd10000;
    localparam logic [16:0] ALPHA_RST  = 17'd19661;
    localparam logic [16:0] ALPHA_ONE  = 17'd65536;
    localparam logic [15:0] RAW_BAD    = 16'hFF00;

    // config register indexes
    localparam logic REG_WARMUP = 1'b0;
    localparam logic REG_ALPHA  = 1'b1;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 40;

    typedef struct packed {
        logic cap;
        logic eval;
        logic med_step;
        logic ema_mul;
        logic ema_add;
        logic ema_sel;   // 0 respiration, 1 heart
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic need_med;
        logic med_last;
    } sts_t;

endpackage

// ===== rtl/vital_sign_median_ema_filter.sv =====
// Vital-sign filter: takes one item at a time and returns exactly one result item for it.
// An item with the subject absent, or with either sample NaN, zero or 0xFF00, clears the
// timer, the rings and the moving average. Otherwise a warm-up timer (warmup_ms, wrapping
// 32-bit time) runs from the first good item; after it both samples enter WINDOW-deep
// rings, and once the rings are full each ring's median (even WINDOW: lower-rounded mean of
// the middle pair) drives an exponential average weighted by avg_weight (Q1.16, capped at
// one). An item that needs no median goes from evaluation straight to the output load; one
// that does also passes through the median scan, which tests one ring entry per cycle,
// and the single shared multiplier, one multiply and one add step per channel. The next
// item can be accepted in the cycle after the result is loaded into the output register,
// even if that result is still waiting.
module vital_sign_median_ema_filter #(
    parameter int WINDOW = vsmef_pkg::WINDOW_DEF    // ring depth, 1 to 15
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    // item in
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // subject_present[0], now_ms[32:1], resp_raw[48:33], resp_nan[49],
    // heart_raw[65:50], heart_nan[66], zero pad[71:67]
    input  logic [vsmef_pkg::S_TDATA_W-1:0]  s_tdata,

    // result out
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // present_out[0], vitals_ok[1], warm_done[2], filtered_ok[3],
    // resp_filtered[19:4], heart_filtered[35:20], zero pad[39:36]
    output logic [vsmef_pkg::M_TDATA_W-1:0]  m_tdata,

    // register writes: index 0 warmup_ms, index 1 avg_weight (bits 16:0)
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic                             cfg_addr,
    input  logic [31:0]                      cfg_data
);

    vsmef_pkg::cmd_t cmd;
    vsmef_pkg::sts_t sts;

    // registers take a write on any cycle
    assign cfg_ready = 1'b1;

    // sequencer: accept, evaluate, median scan, average update, output load
    vsmef_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // timer, rings, median rank test, shared multiplier, output register
    vsmef_dp #(
        .WINDOW (WINDOW)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== rtl/vsmef_dp.sv =====
`include "vital_sign_median_ema_filter_assert.svh"

module vsmef_dp #(
    parameter int WINDOW = vsmef_pkg::WINDOW_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [vsmef_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                             cfg_valid,
    input  logic                             cfg_addr,
    input  logic [31:0]                      cfg_data,
    input  vsmef_pkg::cmd_t                  cmd,
    output vsmef_pkg::sts_t                  sts,
    output logic [vsmef_pkg::M_TDATA_W-1:0]  m_tdata
);

    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam logic [CNT_W-1:0] K_LO     = CNT_W'((WINDOW - 1) / 2);
    localparam logic [CNT_W-1:0] K_HI     = CNT_W'(WINDOW / 2);
    localparam logic [CNT_W-1:0] W_CNT    = CNT_W'(WINDOW);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);

    // config
    logic [31:0] warmup_reg;
    logic [16:0] alpha_reg;

    // captured item
    logic        in_present_reg;
    logic [31:0] in_now_reg;
    logic [15:0] in_resp_reg;
    logic        in_resp_nan_reg;
    logic [15:0] in_heart_reg;
    logic        in_heart_nan_reg;

    // filter state
    logic             timer_reg;
    logic [31:0]      start_reg;
    logic             warmed_reg;
    logic [IDX_W-1:0] wpos_reg;
    logic [CNT_W-1:0] fill_reg;
    logic             seeded_reg;
    logic [15:0]      resp_avg_reg;
    logic [15:0]      heart_avg_reg;

    logic [15:0] resp_ring [WINDOW];
    logic [15:0] heart_ring [WINDOW];

    // median scan
    logic [IDX_W-1:0] med_idx_reg;
    logic [15:0]      resp_lo_reg;
    logic [15:0]      resp_hi_reg;
    logic [15:0]      heart_lo_reg;
    logic [15:0]      heart_hi_reg;

    logic signed [34:0] prod_reg;

    // result flags
    logic res_present_reg;
    logic res_ok_reg;
    logic res_warm_reg;
    logic res_fok_reg;

    logic [vsmef_pkg::M_TDATA_W-1:0] m_data_reg;

    // ---- evaluation of one item ----
    logic             resp_valid;
    logic             heart_valid;
    logic             item_ok;
    logic             go;
    logic [31:0]      start_eff;
    logic             warm_eff;
    logic [31:0]      elapsed;
    logic             warm_hit;
    logic             warm_new;
    logic [IDX_W-1:0] wpos_base;
    logic [CNT_W-1:0] fill_base;
    logic             seeded_base;
    logic [IDX_W-1:0] wpos_new;
    logic [CNT_W-1:0] fill_new;
    logic             need_med;

    always_comb begin
        resp_valid  = !in_resp_nan_reg && (in_resp_reg != 16'd0)
                      && (in_resp_reg != vsmef_pkg::RAW_BAD);
        heart_valid = !in_heart_nan_reg && (in_heart_reg != 16'd0)
                      && (in_heart_reg != vsmef_pkg::RAW_BAD);
        item_ok     = resp_valid && heart_valid;
        go          = in_present_reg && item_ok;
        start_eff   = timer_reg ? start_reg : in_now_reg;
        warm_eff    = timer_reg && warmed_reg;
        elapsed     = in_now_reg - start_eff;
        warm_hit    = !warm_eff && (elapsed >= warmup_reg);
        warm_new    = warm_eff || warm_hit;
        wpos_base   = warm_hit ? '0 : wpos_reg;
        fill_base   = warm_hit ? '0 : fill_reg;
        seeded_base = warm_hit ? 1'b0 : seeded_reg;
        wpos_new    = (wpos_base == LAST_IDX) ? '0 : wpos_base + 1'b1;
        fill_new    = (fill_base == W_CNT) ? W_CNT : fill_base + 1'b1;
        need_med    = go && warm_new && (fill_new == W_CNT);
    end

    // ---- median rank test, one candidate a cycle ----
    logic [15:0]      resp_cand;
    logic [15:0]      heart_cand;
    logic [CNT_W-1:0] resp_lt;
    logic [CNT_W-1:0] resp_le;
    logic [CNT_W-1:0] heart_lt;
    logic [CNT_W-1:0] heart_le;

    always_comb begin
        resp_cand  = resp_ring[med_idx_reg];
        heart_cand = heart_ring[med_idx_reg];
        resp_lt    = '0;
        resp_le    = '0;
        heart_lt   = '0;
        heart_le   = '0;
        for (int j = 0; j < WINDOW; j++) begin
            resp_lt  = resp_lt  + CNT_W'(resp_ring[j]  <  resp_cand);
            resp_le  = resp_le  + CNT_W'(resp_ring[j]  <= resp_cand);
            heart_lt = heart_lt + CNT_W'(heart_ring[j] <  heart_cand);
            heart_le = heart_le + CNT_W'(heart_ring[j] <= heart_cand);
        end
    end

    // ---- moving average ----
    logic [16:0]        resp_sum;
    logic [16:0]        heart_sum;
    logic [15:0]        med_sel;
    logic [15:0]        avg_sel;
    logic [16:0]        alpha_sat;
    logic signed [16:0] diff;
    logic signed [18:0] avg_sum;
    logic [15:0]        avg_new;

    always_comb begin
        resp_sum  = {1'b0, resp_lo_reg} + {1'b0, resp_hi_reg};
        heart_sum = {1'b0, heart_lo_reg} + {1'b0, heart_hi_reg};
        med_sel   = cmd.ema_sel ? heart_sum[16:1] : resp_sum[16:1];
        avg_sel   = cmd.ema_sel ? heart_avg_reg : resp_avg_reg;
        alpha_sat = alpha_reg[16] ? vsmef_pkg::ALPHA_ONE : alpha_reg;
        diff      = $signed({1'b0, med_sel}) - $signed({1'b0, avg_sel});
        avg_sum   = $signed({3'b000, avg_sel}) + prod_reg[34:16];
        avg_new   = seeded_reg ? avg_sum[15:0] : med_sel;
    end

    always_ff @(posedge aclk) begin
        if (cmd.ema_mul) begin
            prod_reg <= $signed({1'b0, alpha_sat}) * diff;
        end
    end

    // ---- config registers ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            warmup_reg <= vsmef_pkg::WARMUP_RST;
            alpha_reg  <= vsmef_pkg::ALPHA_RST;
        end else if (cfg_valid) begin
            case (cfg_addr)
                vsmef_pkg::REG_WARMUP: warmup_reg <= cfg_data;
                vsmef_pkg::REG_ALPHA:  alpha_reg  <= cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // ---- input capture ----
    always_ff @(posedge aclk) begin
        if (cmd.cap) begin
            in_present_reg   <= s_tdata[0];
            in_now_reg       <= s_tdata[32:1];
            in_resp_reg      <= s_tdata[48:33];
            in_resp_nan_reg  <= s_tdata[49];
            in_heart_reg     <= s_tdata[65:50];
            in_heart_nan_reg <= s_tdata[66];
        end
    end

    // ---- rings ----
    always_ff @(posedge aclk) begin
        if (cmd.eval && go && warm_new) begin
            resp_ring[wpos_base]  <= in_resp_reg;
            heart_ring[wpos_base] <= in_heart_reg;
        end
    end

    // ---- filter state ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timer_reg     <= 1'b0;
            start_reg     <= '0;
            warmed_reg    <= 1'b0;
            wpos_reg      <= '0;
            fill_reg      <= '0;
            seeded_reg    <= 1'b0;
            resp_avg_reg  <= '0;
            heart_avg_reg <= '0;
            res_fok_reg   <= 1'b0;
        end else if (cmd.eval) begin
            res_fok_reg <= need_med;
            if (!go) begin
                timer_reg     <= 1'b0;
                start_reg     <= '0;
                warmed_reg    <= 1'b0;
                wpos_reg      <= '0;
                fill_reg      <= '0;
                seeded_reg    <= 1'b0;
                resp_avg_reg  <= '0;
                heart_avg_reg <= '0;
            end else begin
                timer_reg  <= 1'b1;
                start_reg  <= start_eff;
                warmed_reg <= warm_new;
                seeded_reg <= seeded_base;
                if (warm_new) begin
                    wpos_reg <= wpos_new;
                    fill_reg <= fill_new;
                end
            end
        end else if (cmd.ema_add) begin
            if (cmd.ema_sel) begin
                heart_avg_reg <= avg_new;
                seeded_reg    <= 1'b1;
            end else begin
                resp_avg_reg <= avg_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.eval) begin
            res_present_reg <= in_present_reg;
            res_ok_reg      <= item_ok;
            res_warm_reg    <= go && warm_new;
        end
    end

    // ---- median scan ----
    always_ff @(posedge aclk) begin
        if (cmd.eval) begin
            med_idx_reg <= '0;
        end else if (cmd.med_step) begin
            if (med_idx_reg != LAST_IDX) begin
                med_idx_reg <= med_idx_reg + 1'b1;
            end
            if ((resp_lt <= K_LO) && (K_LO < resp_le)) resp_lo_reg <= resp_cand;
            if ((resp_lt <= K_HI) && (K_HI < resp_le)) resp_hi_reg <= resp_cand;
            if ((heart_lt <= K_LO) && (K_LO < heart_le)) heart_lo_reg <= heart_cand;
            if ((heart_lt <= K_HI) && (K_HI < heart_le)) heart_hi_reg <= heart_cand;
        end
    end

    // ---- output register ----
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg <= {4'b0000,
                           res_fok_reg ? heart_avg_reg : 16'd0,
                           res_fok_reg ? resp_avg_reg : 16'd0,
                           res_fok_reg, res_warm_reg, res_ok_reg, res_present_reg};
        end
    end

    assign m_tdata      = m_data_reg;
    assign sts.need_med = need_med;
    assign sts.med_last = (med_idx_reg == LAST_IDX);

    `VSMEF_ASSERT_NOW(a_fill_bound, 1'b1, fill_reg <= W_CNT)
    `VSMEF_ASSERT_NOW(a_fok_full, res_fok_reg, fill_reg == W_CNT && warmed_reg)

endmodule

// ===== rtl/vsmef_ctrl.sv =====
`include "vital_sign_median_ema_filter_assert.svh"

module vsmef_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    input  vsmef_pkg::sts_t sts,
    output vsmef_pkg::cmd_t cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_MED  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_ADD  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       sel_reg;
    logic       sel_next;
    logic       m_valid_reg;
    logic       m_valid_next;

    always_comb begin
        state_next = state_reg;
        sel_next   = sel_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.cap    = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                cmd.eval   = 1'b1;
                sel_next   = 1'b0;
                state_next = sts.need_med ? S_MED : S_DONE;
            end
            S_MED: begin
                cmd.med_step = 1'b1;
                if (sts.med_last) begin
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                cmd.ema_mul = 1'b1;
                cmd.ema_sel = sel_reg;
                state_next  = S_ADD;
            end
            S_ADD: begin
                cmd.ema_add = 1'b1;
                cmd.ema_sel = sel_reg;
                if (sel_reg) begin
                    state_next = S_DONE;
                end else begin
                    sel_next   = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            sel_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sel_reg     <= sel_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;

    `VSMEF_ASSERT_NOW(a_eval_after_accept, state_reg == S_EVAL, $past(s_tvalid && s_tready))
    `VSMEF_ASSERT_NOW(a_no_overwrite, cmd.out_load, !m_valid_reg || m_tready)
    `VSMEF_ASSERT_NEXT(a_med_to_mul, state_reg == S_MED && sts.med_last, state_reg == S_MUL)

endmodule
